// ----- src/rank_count_sorter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rank count sorter
// Concurrent checks with synchronous clock and active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef RANK_COUNT_SORTER_MACROS_SVH
`define RANK_COUNT_SORTER_MACROS_SVH

`ifndef SYNTHESIS

`define RCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rank count sorter check failed");

`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rank count sorter check failed");

`else

`define RCS_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/rcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Rank count sorter package
// Sizes and shared types of the sorter.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int MAX_ELEMS = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int FILL_W    = $clog2(MAX_ELEMS + 1);

  typedef struct packed {
    logic clear;
    logic en;
  } acc_ctrl_t;

endpackage

// ----- src/rcs_ram.sv -----
// ----------------------------------------------------------------------------
// Rank count sorter RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rcs_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rcs_rank_acc.sv -----
// ----------------------------------------------------------------------------
// Rank count sorter rank accumulator
// Shared compare unit: counts stored elements that sort ahead of the pivot.
// ----------------------------------------------------------------------------
module rcs_rank_acc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rcs_pkg::acc_ctrl_t                  ctrl_i,
  input  logic signed [rcs_pkg::DATA_W-1:0]   pivot_i,
  input  logic        [rcs_pkg::IDX_W-1:0]    pivot_idx_i,
  input  logic signed [rcs_pkg::DATA_W-1:0]   sample_i,
  input  logic        [rcs_pkg::IDX_W-1:0]    sample_idx_i,
  output logic        [rcs_pkg::IDX_W-1:0]    count_o
);

  logic [rcs_pkg::IDX_W-1:0] count_q;
  logic [rcs_pkg::IDX_W-1:0] count_d;
  logic                      ahead;

  assign ahead = (sample_i < pivot_i) ||
                 ((sample_i == pivot_i) && (sample_idx_i < pivot_idx_i));

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.en && ahead) begin
      count_d = count_q + rcs_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// ----- src/rank_count_sorter.sv -----
// ----------------------------------------------------------------------------
// Rank count sorter
// Stable ascending sort of up to MAX_ELEMS signed words by comparison counting.
// ----------------------------------------------------------------------------
// Input channel: one element per beat (sample_value_i, is_final_i). Beats are
// taken one per cycle while loading; elements beyond MAX_ELEMS are dropped.
// A beat with is_final_i set closes the set and starts the sort; the block
// does not take input until the whole set has been emitted.
// Sort: each of the n stored elements is ranked by one shared compare unit
// that streams the element RAM read port through the pivot read, pivot load,
// scan, drain and write states. Each element is written straight to its
// sorted position in a second RAM.
// Output channel: n beats (sorted_value_o, end_of_run_o), end_of_run_o high
// on the last; each is read from the sorted RAM once the output register is free.
// The output register holds a beat while the receiver stalls; the next set may
// load while the last beat of a set still waits.
// Reset empties the store and clears the output register.
// ----------------------------------------------------------------------------
`include "rank_count_sorter_macros.svh"

module rank_count_sorter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [rcs_pkg::DATA_W-1:0] sample_value_i,
  input  logic                              is_final_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rcs_pkg::DATA_W-1:0] sorted_value_o,
  output logic                              end_of_run_o
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PIV_RD,
    S_PIV_LD,
    S_SCAN,
    S_DRAIN,
    S_WRITE,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

  state_e                             state_q, state_d;
  logic [rcs_pkg::FILL_W-1:0]         fill_q, fill_d;
  logic [rcs_pkg::FILL_W-1:0]         fill_next;
  logic [rcs_pkg::IDX_W-1:0]          n_last_q, n_last_d;
  logic [rcs_pkg::IDX_W-1:0]          a_q, a_d;
  logic [rcs_pkg::IDX_W-1:0]          b_q, b_d;
  logic [rcs_pkg::IDX_W-1:0]          e_q, e_d;
  logic signed [rcs_pkg::DATA_W-1:0]  pivot_q, pivot_d;
  logic                               cmp_vld_q, cmp_vld_d;
  logic [rcs_pkg::IDX_W-1:0]          cmp_idx_q, cmp_idx_d;
  logic                               out_valid_q, out_valid_d;
  logic signed [rcs_pkg::DATA_W-1:0]  out_value_q, out_value_d;
  logic                               out_last_q, out_last_d;

  logic                               in_fire;
  logic                               has_room;
  logic [rcs_pkg::IDX_W-1:0]          elem_raddr;
  logic [rcs_pkg::DATA_W-1:0]         elem_rdata;
  logic [rcs_pkg::DATA_W-1:0]         sort_rdata;
  logic [rcs_pkg::IDX_W-1:0]          rank_count;
  rcs_pkg::acc_ctrl_t                 acc_ctrl;

  assign in_ready_o = (state_q == S_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign has_room   = (fill_q < rcs_pkg::FILL_W'(rcs_pkg::MAX_ELEMS));
  assign fill_next  = has_room ? fill_q + rcs_pkg::FILL_W'(1) : fill_q;
  assign elem_raddr = (state_q == S_PIV_RD) ? a_q : b_q;

  assign acc_ctrl.clear = (state_q == S_PIV_LD);
  assign acc_ctrl.en    = cmp_vld_q;

  rcs_ram #(
    .DATA_W (rcs_pkg::DATA_W),
    .ADDR_W (rcs_pkg::IDX_W)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && has_room),
    .waddr_i (fill_q[rcs_pkg::IDX_W-1:0]),
    .wdata_i (sample_value_i),
    .raddr_i (elem_raddr),
    .rdata_o (elem_rdata)
  );

  rcs_ram #(
    .DATA_W (rcs_pkg::DATA_W),
    .ADDR_W (rcs_pkg::IDX_W)
  ) u_sort_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WRITE),
    .waddr_i (rank_count),
    .wdata_i (pivot_q),
    .raddr_i (e_q),
    .rdata_o (sort_rdata)
  );

  rcs_rank_acc u_rank_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (acc_ctrl),
    .pivot_i      (pivot_q),
    .pivot_idx_i  (a_q),
    .sample_i     ($signed(elem_rdata)),
    .sample_idx_i (cmp_idx_q),
    .count_o      (rank_count)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    n_last_d    = n_last_q;
    a_d         = a_q;
    b_d         = b_q;
    e_d         = e_q;
    pivot_d     = pivot_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          fill_d = fill_next;
          if (is_final_i) begin
            n_last_d = rcs_pkg::IDX_W'(fill_next - rcs_pkg::FILL_W'(1));
            a_d      = '0;
            state_d  = S_PIV_RD;
          end
        end
      end
      S_PIV_RD: begin
        state_d = S_PIV_LD;
      end
      S_PIV_LD: begin
        pivot_d = $signed(elem_rdata);
        b_d     = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmp_vld_d = 1'b1;
        cmp_idx_d = b_q;
        if (b_q == n_last_q) begin
          state_d = S_DRAIN;
        end else begin
          b_d = b_q + rcs_pkg::IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (a_q == n_last_q) begin
          e_d     = '0;
          state_d = S_EMIT_RD;
        end else begin
          a_d     = a_q + rcs_pkg::IDX_W'(1);
          state_d = S_PIV_RD;
        end
      end
      S_EMIT_RD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        out_valid_d = 1'b1;
        out_value_d = $signed(sort_rdata);
        out_last_d  = (e_q == n_last_q);
        if (e_q == n_last_q) begin
          fill_d  = '0;
          state_d = S_LOAD;
        end else begin
          e_d     = e_q + rcs_pkg::IDX_W'(1);
          state_d = S_EMIT_RD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      fill_q      <= '0;
      n_last_q    <= '0;
      a_q         <= '0;
      b_q         <= '0;
      e_q         <= '0;
      pivot_q     <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      n_last_q    <= n_last_d;
      a_q         <= a_d;
      b_q         <= b_d;
      e_q         <= e_d;
      pivot_q     <= pivot_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      out_valid_q <= out_valid_d;
      out_value_q <= out_value_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign end_of_run_o   = out_last_q;

  `RCS_ASSERT_SAME(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= rcs_pkg::FILL_W'(rcs_pkg::MAX_ELEMS))
  `RCS_ASSERT_SAME(a_pos_in_set, clk_i, rst_ni, state_q == S_WRITE, rank_count <= n_last_q)
  `RCS_ASSERT_SAME(a_out_free, clk_i, rst_ni, state_q == S_EMIT_LD, !out_valid_q)
  `RCS_ASSERT_SAME(a_cmp_in_set, clk_i, rst_ni, cmp_vld_q, cmp_idx_q <= n_last_q)
  `RCS_ASSERT_NEXT(a_set_done, clk_i, rst_ni, (state_q == S_EMIT_LD) && (e_q == n_last_q), (state_q == S_LOAD) && (fill_q == '0) && out_valid_q && out_last_q)

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rank count sorter testbench
// Feeds sets of signed words, from a directed table and then at random, and
// checks every sorted beat against a stable ascending sort of the set.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [rcs_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  last;
  } sorted_beat_t;

  typedef struct packed {
    word_t value;
    logic  fin;
    logic  typed;
    word_t exp_value;
  } stim_row_t;

  localparam int N_DIRECTED = 22;
  localparam int ITEM_GOAL  = 320;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN      = 200;
  localparam int HOLD_AT    = 30;
  localparam int HOLD_LEN   = 500;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF},
    '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
    '{32'sh00000000, 1'b1, 1'b1, 32'sh00000000},
    '{32'shFFFFFFFF, 1'b1, 1'b1, 32'shFFFFFFFF},
    '{32'sh55555555, 1'b0, 1'b0, 32'sh0},
    '{32'shAAAAAAAA, 1'b0, 1'b0, 32'sh0},
    '{32'sh55555555, 1'b0, 1'b0, 32'sh0},
    '{32'sh80000000, 1'b0, 1'b0, 32'sh0},
    '{32'sh7FFFFFFF, 1'b0, 1'b0, 32'sh0},
    '{32'shFFFFFFFF, 1'b0, 1'b0, 32'sh0},
    '{32'sh00000000, 1'b0, 1'b0, 32'sh0},
    '{32'sh00000001, 1'b1, 1'b0, 32'sh0},
    '{32'sh00000007, 1'b0, 1'b0, 32'sh0},
    '{32'sh00000007, 1'b0, 1'b0, 32'sh0},
    '{32'sh00000007, 1'b1, 1'b0, 32'sh0},
    '{32'sh00000003, 1'b0, 1'b0, 32'sh0},
    '{32'sh00000002, 1'b0, 1'b0, 32'sh0},
    '{32'sh00000001, 1'b0, 1'b0, 32'sh0},
    '{32'sh00000000, 1'b0, 1'b0, 32'sh0},
    '{32'shFFFFFFFF, 1'b1, 1'b0, 32'sh0},
    '{32'sh7FFFFFFF, 1'b0, 1'b0, 32'sh0},
    '{32'sh80000000, 1'b1, 1'b0, 32'sh0}
  };

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  word_t sample_value_i;
  logic  is_final_i;
  logic  out_valid_o;
  logic  out_ready_i;
  word_t sorted_value_o;
  logic  end_of_run_o;

  word_t        set_elems[$];
  sorted_beat_t fresh_beats[$];
  sorted_beat_t pending_beats[$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  items_sent;
  bit           steady;

  rank_count_sorter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_value_i(sample_value_i),
    .is_final_i    (is_final_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .end_of_run_o  (end_of_run_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t draw_sample(int unsigned mode);
    case (mode)
      0: return $urandom;
      1: return int'($urandom_range(0, 6)) - 3;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh80000000;
          1: return 32'sh7FFFFFFF;
          2: return 32'sh0;
          3: return 32'shFFFFFFFF;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // store one element while the set has room; on the closing beat build the stable ascending order
  function automatic void absorb_sample(word_t v, logic f);
    word_t        ordered[$];
    int           j;
    sorted_beat_t b;
    fresh_beats.delete();
    if (set_elems.size() < rcs_pkg::MAX_ELEMS) set_elems.push_back(v);
    if (!f) return;
    foreach (set_elems[i]) begin
      j = ordered.size();
      while (j > 0 && ordered[j-1] > set_elems[i]) j--;
      ordered.insert(j, set_elems[i]);
    end
    foreach (ordered[i]) begin
      b.value = ordered[i];
      b.last  = (i == ordered.size() - 1);
      fresh_beats.push_back(b);
    end
    set_elems.delete();
  endfunction

  task automatic send_beat(word_t v, logic f, logic typed, word_t tv);
    int unsigned gap;
    gap = steady ? 0 : idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= v;
    is_final_i     <= f;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_sample(v, f);
    if (typed) pending_beats.push_back('{tv, 1'b1});
    else foreach (fresh_beats[i]) pending_beats.push_back(fresh_beats[i]);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic void report_mismatch(sorted_beat_t want, sorted_beat_t got, bit orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan)
        $display("unexpected beat: value %0d last %0b", got.value, got.last);
      else
        $display("beat mismatch: expected value %0d last %0b, got value %0d last %0b",
                 want.value, want.last, got.value, got.last);
    end
  endfunction

  always @(posedge clk_i) begin
    sorted_beat_t got;
    sorted_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{sorted_value_o, end_of_run_o};
      results_seen++;
      if (pending_beats.size() == 0) begin
        report_mismatch(got, got, 1'b1);
      end else begin
        want = pending_beats.pop_front();
        if (got.value !== want.value || got.last !== want.last)
          report_mismatch(want, got, 1'b0);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("rank_count_sorter: mismatch");
    $finish;
  end

  initial begin : receiver
    bit held;
    int unsigned gap;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(50, 200)) @(negedge clk_i);
      else repeat ($urandom_range(1, 24)) @(negedge clk_i);
      gap = idle_gap();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  initial begin : sender
    int unsigned set_no;
    int unsigned set_len;
    int unsigned mode;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_value_i = '0;
    is_final_i     = 1'b0;
    mismatches     = 0;
    results_seen   = 0;
    items_sent     = 0;
    steady         = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      send_beat(DIRECTED[i].value, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].exp_value);

    set_no = 0;
    while (items_sent < ITEM_GOAL) begin
      case (set_no)
        2:  set_len = rcs_pkg::MAX_ELEMS;
        6:  set_len = rcs_pkg::MAX_ELEMS + 1;
        10: set_len = rcs_pkg::MAX_ELEMS + 6;
        default: set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
      endcase
      if (set_no == 8) begin
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (pending_beats.size() != 0);
      end
      mode   = $urandom_range(0, 2);
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < set_len; k++)
        send_beat(draw_sample(mode), k == set_len - 1, 1'b0, '0);
      set_no++;
    end
    in_valid_i <= 1'b0;
    steady     = 1'b0;

    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    if (mismatches == 0 && pending_beats.size() == 0)
      $display("rank_count_sorter: match");
    else
      $display("rank_count_sorter: mismatch");
    $finish;
  end

endmodule
